// File: sv/hstpg_pkg.sv
// hstpg_pkg: shared types and constants for the hash-seeded thumbnail pixel generator.
// Holds the command codes, the hash request struct, the FNV-1a basis and the /127 helper.
// No dependencies.
`default_nettype none

package hstpg_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ABSORB = 2'd1,
    CMD_RENDER = 2'd2
  } cmd_t;

  // request from the input stage to the hash register
  typedef struct packed {
    logic       fire;
    logic [1:0] command;
    logic [7:0] text_byte;
  } hash_req_t;

  localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;

  localparam int DISC_R2      = 23 * 23;
  localparam int SHADE_DIV    = 127;
  localparam int SHADE_BASE   = 70;
  localparam int ACCENT_FLOOR = 80;
  localparam int BG_BASE      = 22;
  localparam int BG_G_OFFSET  = 5;
  localparam int BG_B_OFFSET  = 11;

  localparam int LANE_R_SHIFT = 0;
  localparam int LANE_G_SHIFT = 13;
  localparam int LANE_B_SHIFT = 26;

  // floor(p / 127): p = q0*128 + b = q0*127 + (q0 + b), so at most two corrections
  // while q0 + b < 3*127, which holds for the render products (at most 207*101).
  function automatic logic [7:0] div127(input logic [14:0] p);
    logic [7:0] q0;
    logic [8:0] r;
    q0 = p[14:7];
    r  = {2'b00, p[6:0]} + {1'b0, q0};
    return q0 + 8'(r >= 9'(2 * SHADE_DIV)) + 8'(r >= 9'(SHADE_DIV));
  endfunction

endpackage

`default_nettype wire

// File: sv/hstpg_hash.sv
// hstpg_hash: 64-bit FNV-1a running hash register (clear and absorb).
// Depends on hstpg_pkg for the request struct, command codes and offset basis.
`default_nettype none

module hstpg_hash (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire hstpg_pkg::hash_req_t req,
  output logic [63:0]               hash
);

  logic [63:0] mixed;
  logic [63:0] hash_next;

  // prime = 2^40 + 0x1B3, so the product is a handful of shifted adds
  assign mixed = hash ^ {56'd0, req.text_byte};

  always_comb begin
    hash_next = hash;
    if (req.fire) begin
      case (req.command)
        hstpg_pkg::CMD_CLEAR:  hash_next = hstpg_pkg::FNV_BASIS;
        hstpg_pkg::CMD_ABSORB: hash_next = (mixed << 40) + (mixed << 8) + (mixed << 7)
                                         + (mixed << 5) + (mixed << 4) + (mixed << 1)
                                         + mixed;
        default:               hash_next = hash;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= hstpg_pkg::FNV_BASIS;
    end else begin
      hash <= hash_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/hash_seeded_thumbnail_pixel_generator.sv
// Hash-seeded thumbnail pixel generator: hash absorb and pixel render, one word per clock
//   unless m_axis stalls. Path: a render word passes the input, product and result registers
//   before it shows on m_axis; clear and absorb retire from the input register.
// Throughput: one word per cycle while m_axis does not stall; the hash update (xor + shift-add
//   by the prime) is a loop through the hash register alone, and it sets this.
// Reset: rst (synchronous) loads the hash with the FNV-1a offset basis and empties all stages.
// Depends on hstpg_pkg and hstpg_hash.
`default_nettype none

module hash_seeded_thumbnail_pixel_generator #(
  parameter int IMAGE_WIDTH  = 64,
  parameter int IMAGE_HEIGHT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // text_byte[7:0], pixel_x[13:8], pixel_y[19:14], 0
  input  wire logic [1:0]  s_axis_tuser,  // command[1:0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata   // red[7:0], green[15:8], blue[23:16], fingerprint[87:24]
);

  // image center; coordinates are 6 bits, center is at most 128, so 9-bit signed offsets
  localparam int CX = IMAGE_WIDTH / 2;
  localparam int CY = IMAGE_HEIGHT / 2;

  // ---------------------------------------------------------------------------
  // stage 1: input register
  // ---------------------------------------------------------------------------
  logic                in_v;
  hstpg_pkg::cmd_t     in_cmd;
  logic [7:0]          in_byte;
  logic [5:0]          in_x;
  logic [5:0]          in_y;

  logic                in_go;     // word in stage 1 retires this cycle
  logic                mid_v;
  logic                mid_go;
  logic                mid_ready;
  logic                out_v;
  logic                out_ready;
  logic                s_accept;

  // downstream flow: each stage moves when the next one is empty or draining
  assign out_ready     = !out_v || m_axis_tready;
  assign mid_go        = mid_v && out_ready;
  assign mid_ready     = !mid_v || mid_go;
  // only a render needs room downstream; clear, absorb and the unused code retire at once
  assign in_go         = in_v && ((in_cmd != hstpg_pkg::CMD_RENDER) || mid_ready);
  assign s_axis_tready = !in_v || in_go;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_accept) begin
      in_v <= 1'b1;
    end else if (in_go) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_cmd  <= hstpg_pkg::cmd_t'(s_axis_tuser);
      in_byte <= s_axis_tdata[7:0];
      in_x    <= s_axis_tdata[13:8];
      in_y    <= s_axis_tdata[19:14];
    end
  end

  // ---------------------------------------------------------------------------
  // running hash; updated in word order as stage 1 retires
  // ---------------------------------------------------------------------------
  hstpg_pkg::hash_req_t hash_req;
  logic [63:0]          hash;

  assign hash_req.fire      = in_go;
  assign hash_req.command   = in_cmd;
  assign hash_req.text_byte = in_byte;

  hstpg_hash u_hash (
    .clk  (clk),
    .rst  (rst),
    .req  (hash_req),
    .hash (hash)
  );

  // ---------------------------------------------------------------------------
  // render, first half: disc test, motif bit, shade, accent products
  // ---------------------------------------------------------------------------
  logic signed [8:0]  dx;
  logic signed [8:0]  dy;
  logic signed [17:0] dx_sq;
  logic signed [17:0] dy_sq;
  logic [15:0]        r2;
  logic               in_disc;
  logic [4:0]         motif_idx;
  logic               motif;
  logic [4:0]         shade_lo;
  logic [6:0]         shade;
  logic [7:0]         accent_r;
  logic [7:0]         accent_g;
  logic [7:0]         accent_b;
  logic [14:0]        prod_r;
  logic [14:0]        prod_g;
  logic [14:0]        prod_b;
  logic [2:0]         stripe;
  logic [4:0]         bg;

  assign dx      = $signed({3'b000, in_x}) - $signed(9'(CX));
  assign dy      = $signed({3'b000, in_y}) - $signed(9'(CY));
  assign dx_sq   = dx * dx;
  assign dy_sq   = dy * dy;
  // squares are at most 128^2, so 15 bits each
  assign r2      = {1'b0, dx_sq[14:0]} + {1'b0, dy_sq[14:0]};
  assign in_disc = r2 < 16'(hstpg_pkg::DISC_R2);

  // (x/8 + 5*(y/8)) mod 32
  assign motif_idx = {2'b00, in_x[5:3]} + {in_y[5:3], 2'b00} + {2'b00, in_y[5:3]};
  assign motif     = hash[motif_idx];

  // (5x + 3y + hash) mod 32, all in five bits
  assign shade_lo = ({in_x[2:0], 2'b00} + in_x[4:0]) + ({in_y[3:0], 1'b0} + in_y[4:0])
                  + hash[4:0];
  assign shade    = 7'(hstpg_pkg::SHADE_BASE) + {2'b00, shade_lo};

  assign accent_r = 8'(hstpg_pkg::ACCENT_FLOOR)
                  + {1'b0, hash[hstpg_pkg::LANE_R_SHIFT +: 7]};
  assign accent_g = 8'(hstpg_pkg::ACCENT_FLOOR)
                  + {1'b0, hash[hstpg_pkg::LANE_G_SHIFT +: 7]};
  assign accent_b = 8'(hstpg_pkg::ACCENT_FLOOR)
                  + {1'b0, hash[hstpg_pkg::LANE_B_SHIFT +: 7]};

  // 207 * 101 max, fits 15 bits
  assign prod_r = accent_r * shade;
  assign prod_g = accent_g * shade;
  assign prod_b = accent_b * shade;

  // striped background base: 22 + ((x + y) mod 8)
  assign stripe = in_x[2:0] + in_y[2:0];
  assign bg     = 5'(hstpg_pkg::BG_BASE) + {2'b00, stripe};

  // ---------------------------------------------------------------------------
  // stage 2: product register (hash snapshot travels with the pixel)
  // ---------------------------------------------------------------------------
  logic        mid_accent;
  logic [14:0] mid_prod_r;
  logic [14:0] mid_prod_g;
  logic [14:0] mid_prod_b;
  logic [4:0]  mid_bg;
  logic [63:0] mid_hash;
  logic        load_mid;

  assign load_mid = in_go && (in_cmd == hstpg_pkg::CMD_RENDER);

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_v <= 1'b0;
    end else if (load_mid) begin
      mid_v <= 1'b1;
    end else if (mid_go) begin
      mid_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_mid) begin
      mid_accent <= in_disc && motif;
      mid_prod_r <= prod_r;
      mid_prod_g <= prod_g;
      mid_prod_b <= prod_b;
      mid_bg     <= bg;
      mid_hash   <= hash;
    end
  end

  // ---------------------------------------------------------------------------
  // render, second half: divide by 127 or pick background
  // ---------------------------------------------------------------------------
  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;

  always_comb begin
    if (mid_accent) begin
      red_next   = hstpg_pkg::div127(mid_prod_r);
      green_next = hstpg_pkg::div127(mid_prod_g);
      blue_next  = hstpg_pkg::div127(mid_prod_b);
    end else begin
      red_next   = {3'b000, mid_bg};
      green_next = {3'b000, mid_bg} + 8'(hstpg_pkg::BG_G_OFFSET);
      blue_next  = {3'b000, mid_bg} + 8'(hstpg_pkg::BG_B_OFFSET);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: result register
  // ---------------------------------------------------------------------------
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [63:0] out_hash;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (mid_go) begin
      out_v <= 1'b1;
    end else if (m_axis_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_go) begin
      out_red   <= red_next;
      out_green <= green_next;
      out_blue  <= blue_next;
      out_hash  <= mid_hash;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {out_hash, out_blue, out_green, out_red};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // reset leaves the hash at the offset basis
  a_reset_basis: assert property (@(posedge clk) rst |=> (hash == hstpg_pkg::FNV_BASIS))
    else $error("hash not at offset basis after reset");

  // the hash moves only when a word retires from stage 1
  a_hash_hold: assert property (@(posedge clk) disable iff (rst)
    !in_go |=> $stable(hash))
    else $error("hash changed with no word retiring");

  // a retiring render always lands in the product register
  a_render_lands: assert property (@(posedge clk) disable iff (rst)
    load_mid |=> mid_v)
    else $error("render word lost between stages");

  // a blocked product register keeps its pixel's hash and red product
  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    (mid_v && !out_ready) |=> (mid_v && $stable(mid_hash) && $stable(mid_prod_r)))
    else $error("stalled pixel overwritten");

endmodule

`default_nettype wire
